// ----- rtl/core/hsfl_pkg.sv -----
// Shared types, codes and reset values for the health supervisor.
package hsfl_pkg;

	localparam int SENSOR_SLOTS_DEF = 8;

	// Field widths
	localparam int IDX_W   = 3;
	localparam int CO2_W   = 16;
	localparam int REQ_W   = 4;
	localparam int DELAY_W = 8;
	localparam int PING_W  = 9;
	localparam int SENS_W  = 17;
	localparam int CODE_W  = 3;
	localparam int COLOR_W = 3;
	localparam int LINK_W  = 3;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_REQUIRED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PING     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SENSOR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CO2_LOW  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CO2_HIGH = 3'd5;

	localparam logic [REQ_W-1:0]   REQUIRED_RST = 4'd1;
	localparam logic [DELAY_W-1:0] DELAY_RST    = 8'd120;
	localparam logic [PING_W-1:0]  PING_RST     = 9'd300;
	localparam logic [SENS_W-1:0]  SENSOR_RST   = 17'd86400;
	localparam logic [CO2_W-1:0]   CO2_LOW_RST  = 16'd300;
	localparam logic [CO2_W-1:0]   CO2_HIGH_RST = 16'd20000;

	localparam logic [PING_W-1:0] PING_CNT_MAX = '1;
	localparam logic [SENS_W-1:0] SENS_CNT_MAX = '1;

	// Item modes
	localparam logic MODE_REPORT = 1'b0;
	localparam logic MODE_TICK   = 1'b1;

	// LED colours
	localparam logic [COLOR_W-1:0] COL_OFF    = 3'd0;
	localparam logic [COLOR_W-1:0] COL_RED    = 3'd1;
	localparam logic [COLOR_W-1:0] COL_YELLOW = 3'd2;
	localparam logic [COLOR_W-1:0] COL_GREEN  = 3'd3;
	localparam logic [COLOR_W-1:0] COL_BLUE   = 3'd4;

	// Error codes
	localparam logic [CODE_W-1:0] ERR_NONE     = 3'd0;
	localparam logic [CODE_W-1:0] ERR_SUPPLY   = 3'd1;
	localparam logic [CODE_W-1:0] ERR_EXHAUST  = 3'd2;
	localparam logic [CODE_W-1:0] ERR_INDOOR   = 3'd3;
	localparam logic [CODE_W-1:0] ERR_OUTDOOR  = 3'd4;
	localparam logic [CODE_W-1:0] ERR_SENSORS  = 3'd5;

	// Link states
	localparam logic [LINK_W-1:0] LS_CONNECTING = 3'd1;
	localparam logic [LINK_W-1:0] LS_WPS        = 3'd2;
	localparam logic [LINK_W-1:0] LS_CONNECTED  = 3'd3;
	localparam logic [LINK_W-1:0] LS_READY      = 3'd4;
	localparam logic [LINK_W-1:0] LS_IP         = 3'd5;

	typedef struct packed {
		logic [REQ_W-1:0]   required_sensors;
		logic [DELAY_W-1:0] motor_fault_delay;
		logic [PING_W-1:0]  ping_timeout;
		logic [SENS_W-1:0]  sensor_timeout;
		logic [CO2_W-1:0]   co2_low;
		logic [CO2_W-1:0]   co2_high;
	} hsfl_cfg_t;

	typedef struct packed {
		logic              ping_seen;
		logic              fw_updating;
		logic [LINK_W-1:0] link_state;
		logic [1:0]        fan_faults;
		logic              clear_pressed;
		logic [1:0]        temp_faults;
		logic              exhaust_turning;
		logic              ventilation_off;
	} hsfl_tick_t;

	typedef struct packed {
		logic ok_short;
		logic none_ok;
		logic co2_bad;
	} hsfl_scan_t;

	typedef struct packed {
		logic [CODE_W-1:0]  error_code;
		logic [COLOR_W-1:0] link_color;
		logic               link_flash;
		logic [COLOR_W-1:0] fault_color;
		logic               fault_flash;
		logic               restart_link;
		logic               reboot_request;
	} hsfl_result_t;

endpackage

// ----- rtl/core/hsfl_ifs.sv -----
// Handshake channels of the health supervisor: items, results, register writes.
interface hsfl_item_if;
	import hsfl_pkg::*;
	logic              valid;
	logic              ready;
	logic              mode;
	logic [IDX_W-1:0]  sensor_index;
	logic              sensor_ok;
	logic [CO2_W-1:0]  co2_value;
	logic              ping_seen;
	logic              fw_updating;
	logic [LINK_W-1:0] link_state;
	logic [1:0]        fan_faults;
	logic              clear_pressed;
	logic [1:0]        temp_faults;
	logic              exhaust_turning;
	logic              ventilation_off;

	modport source (output valid, mode, sensor_index, sensor_ok, co2_value, ping_seen,
		fw_updating, link_state, fan_faults, clear_pressed, temp_faults, exhaust_turning,
		ventilation_off, input ready);
	modport sink (input valid, mode, sensor_index, sensor_ok, co2_value, ping_seen,
		fw_updating, link_state, fan_faults, clear_pressed, temp_faults, exhaust_turning,
		ventilation_off, output ready);
endinterface

interface hsfl_result_if;
	import hsfl_pkg::*;
	logic               valid;
	logic               ready;
	logic [CODE_W-1:0]  error_code;
	logic [COLOR_W-1:0] link_color;
	logic               link_flash;
	logic [COLOR_W-1:0] fault_color;
	logic               fault_flash;
	logic               restart_link;
	logic               reboot_request;

	modport source (output valid, error_code, link_color, link_flash, fault_color,
		fault_flash, restart_link, reboot_request, input ready);
	modport sink (input valid, error_code, link_color, link_flash, fault_color,
		fault_flash, restart_link, reboot_request, output ready);
endinterface

interface hsfl_cfg_if;
	import hsfl_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/health_supervisor_fault_latch.sv -----
// A sensor report word is written to the slot table in its accept cycle and gives no result;
// the next word may follow in the cycle after. A tick word walks all SENSOR_SLOTS slots of the
// table RAM, one read a cycle, and no next word is taken until the scan is done and the output
// register is free; the result then sits in that output register and a new word is accepted
// while it waits. Slots come up reading as zero through per-slot valid bits, so there is no
// clearing pass after reset. Register writes are always accepted.
module health_supervisor_fault_latch #(
	parameter int SENSOR_SLOTS = hsfl_pkg::SENSOR_SLOTS_DEF
) (
	input logic           clk,
	input logic           arst_n,
	hsfl_item_if.sink     item,
	hsfl_result_if.source result,
	hsfl_cfg_if.sink      cfg
);
	import hsfl_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0]   state_q;
	hsfl_cfg_t    cfg_q;
	hsfl_tick_t   tick_q;
	hsfl_scan_t   summary;
	hsfl_result_t tick_res;
	hsfl_result_t res_q;
	logic         out_vld_q;
	logic         accept;
	logic         rpt_wr;
	logic         tick_go;
	logic         scan_done;
	logic         out_free;
	logic         commit;

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign rpt_wr     = accept && (item.mode == MODE_REPORT);
	assign tick_go    = accept && (item.mode == MODE_TICK);
	assign out_free   = !out_vld_q || result.ready;
	assign commit     = (((state_q == ST_SCAN) && scan_done) || (state_q == ST_HOLD)) && out_free;

	// Registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.required_sensors  <= REQUIRED_RST;
			cfg_q.motor_fault_delay <= DELAY_RST;
			cfg_q.ping_timeout      <= PING_RST;
			cfg_q.sensor_timeout    <= SENSOR_RST;
			cfg_q.co2_low           <= CO2_LOW_RST;
			cfg_q.co2_high          <= CO2_HIGH_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_REQUIRED: cfg_q.required_sensors  <= cfg.data[REQ_W-1:0];
				REG_DELAY:    cfg_q.motor_fault_delay <= cfg.data[DELAY_W-1:0];
				REG_PING:     cfg_q.ping_timeout      <= cfg.data[PING_W-1:0];
				REG_SENSOR:   cfg_q.sensor_timeout    <= cfg.data[SENS_W-1:0];
				REG_CO2_LOW:  cfg_q.co2_low           <= cfg.data[CO2_W-1:0];
				REG_CO2_HIGH: cfg_q.co2_high          <= cfg.data[CO2_W-1:0];
				default: ;
			endcase
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (tick_go) state_q <= ST_SCAN;
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= out_free ? ST_IDLE : ST_HOLD;
					end
				end
				ST_HOLD: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tick_go) begin
			tick_q.ping_seen       <= item.ping_seen;
			tick_q.fw_updating     <= item.fw_updating;
			tick_q.link_state      <= item.link_state;
			tick_q.fan_faults      <= item.fan_faults;
			tick_q.clear_pressed   <= item.clear_pressed;
			tick_q.temp_faults     <= item.temp_faults;
			tick_q.exhaust_turning <= item.exhaust_turning;
			tick_q.ventilation_off <= item.ventilation_off;
		end
	end

	hsfl_table #(
		.SENSOR_SLOTS (SENSOR_SLOTS)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (rpt_wr),
		.wr_index (item.sensor_index),
		.wr_ok    (item.sensor_ok),
		.wr_co2   (item.co2_value),
		.start    (tick_go),
		.cfg      (cfg_q),
		.done     (scan_done),
		.summary  (summary)
	);

	hsfl_tick u_tick (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (commit),
		.tick   (tick_q),
		.cfg    (cfg_q),
		.scan   (summary),
		.res    (tick_res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (commit) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_q <= tick_res;
		end
	end

	assign result.valid          = out_vld_q;
	assign result.error_code     = res_q.error_code;
	assign result.link_color     = res_q.link_color;
	assign result.link_flash     = res_q.link_flash;
	assign result.fault_color    = res_q.fault_color;
	assign result.fault_flash    = res_q.fault_flash;
	assign result.restart_link   = res_q.restart_link;
	assign result.reboot_request = res_q.reboot_request;

`ifndef NO_ASSERTIONS
	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |-> (state_q == ST_SCAN))
		else $error("table scan finished outside a tick");
	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(commit))
		else $error("result word appeared without a tick");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> (!out_vld_q || result.ready))
		else $error("result word overwritten before it was taken");
`endif

endmodule

// ----- rtl/core/hsfl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hsfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/hsfl_table.sv -----
// Sensor slot table: RAM with per-slot valid bits and a slot-by-slot scan engine.
module hsfl_table #(
	parameter int SENSOR_SLOTS = hsfl_pkg::SENSOR_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [hsfl_pkg::IDX_W-1:0]    wr_index,
	input  logic                          wr_ok,
	input  logic [hsfl_pkg::CO2_W-1:0]    wr_co2,
	input  logic                          start,
	input  hsfl_pkg::hsfl_cfg_t           cfg,
	output logic                          done,
	output hsfl_pkg::hsfl_scan_t          summary
);
	import hsfl_pkg::*;

	localparam int SLOT_AW = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;
	localparam int CNT_W   = $clog2(SENSOR_SLOTS + 1);
	localparam int XW      = 5;
	localparam int ENT_W   = CO2_W + 1;

	logic [XW-1:0]           wr_idx_x;
	logic                    wr_go;
	logic [SLOT_AW-1:0]      waddr;
	logic [SENSOR_SLOTS-1:0] vld_q;

	logic                    busy_q;
	logic [SLOT_AW-1:0]      rd_addr_q;
	logic                    rd_last;
	logic                    rd_vld_s1;
	logic                    rd_last_s1;
	logic [SLOT_AW-1:0]      rd_idx_s1;
	logic                    ent_vld_s1;
	logic [ENT_W-1:0]        rdata;

	logic                    ent_ok;
	logic [CO2_W-1:0]        ent_co2;
	logic                    chk_slot;
	logic [CNT_W-1:0]        ok_cnt_q;
	logic                    co2_bad_q;
	logic                    done_q;

	// Slots past the table size are dropped.
	assign wr_idx_x = XW'(wr_index);
	assign wr_go    = wr_en && (wr_idx_x < XW'(SENSOR_SLOTS));
	assign waddr    = wr_idx_x[SLOT_AW-1:0];
	assign rd_last  = (rd_addr_q == SLOT_AW'(SENSOR_SLOTS - 1));

	hsfl_ram #(
		.WIDTH (ENT_W),
		.DEPTH (SENSOR_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (wr_go),
		.waddr (waddr),
		.wdata ({wr_ok, wr_co2}),
		.re    (busy_q),
		.raddr (rd_addr_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_go) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	// Read issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			rd_addr_q  <= '0;
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
			rd_idx_s1  <= '0;
			ent_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1  <= busy_q;
			rd_last_s1 <= busy_q && rd_last;
			rd_idx_s1  <= rd_addr_q;
			ent_vld_s1 <= vld_q[rd_addr_q];
			if (start) begin
				busy_q    <= 1'b1;
				rd_addr_q <= '0;
			end else if (busy_q) begin
				if (rd_last) begin
					busy_q <= 1'b0;
				end else begin
					rd_addr_q <= rd_addr_q + 1'b1;
				end
			end
		end
	end

	// A never-written slot reads as zero.
	assign ent_ok   = ent_vld_s1 && rdata[ENT_W-1];
	assign ent_co2  = ent_vld_s1 ? rdata[CO2_W-1:0] : '0;
	assign chk_slot = (rd_idx_s1 != '0) && (XW'(rd_idx_s1) < XW'(cfg.required_sensors));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_cnt_q  <= '0;
			co2_bad_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= rd_vld_s1 && rd_last_s1;
			if (start) begin
				ok_cnt_q  <= '0;
				co2_bad_q <= 1'b0;
			end else if (rd_vld_s1) begin
				ok_cnt_q <= ok_cnt_q + CNT_W'(ent_ok);
				if (chk_slot && ((ent_co2 < cfg.co2_low) || (ent_co2 > cfg.co2_high))) begin
					co2_bad_q <= 1'b1;
				end
			end
		end
	end

	assign done             = done_q;
	assign summary.ok_short = XW'(ok_cnt_q) < XW'(cfg.required_sensors);
	assign summary.none_ok  = (ok_cnt_q == '0);
	assign summary.co2_bad  = co2_bad_q;

`ifndef NO_ASSERTIONS
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(rd_vld_s1 && rd_last_s1))
		else $error("scan done without its last slot");
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !wr_en)
		else $error("table written during a scan");
	a_start_when_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q && !rd_vld_s1)
		else $error("scan restarted while running");
`endif

endmodule

// ----- rtl/core/hsfl_tick.sv -----
// Per-tick supervisor state: watchdogs, fan fault latch and LED logic.
module hsfl_tick (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   commit,
	input  hsfl_pkg::hsfl_tick_t   tick,
	input  hsfl_pkg::hsfl_cfg_t    cfg,
	input  hsfl_pkg::hsfl_scan_t   scan,
	output hsfl_pkg::hsfl_result_t res
);
	import hsfl_pkg::*;

	logic [PING_W-1:0]  ping_cnt_q,  ping_inc, ping_nxt;
	logic [SENS_W-1:0]  sens_cnt_q,  sens_nxt;
	logic               no_sens_q,   no_sens_nxt;
	logic [DELAY_W-1:0] timer_q,     timer_nxt;
	logic [1:0]         latched_q,   latched_nxt;
	logic               ack_q,       ack_nxt;
	logic [COLOR_W-1:0] lcol_q,      lcol_nxt;
	logic               lflash_q,    lflash_nxt;
	logic               fflash_q,    fflash_nxt;
	logic               restart;
	logic               reboot;
	logic [CODE_W-1:0]  fan_err;
	logic [CODE_W-1:0]  err;
	logic [COLOR_W-1:0] fcol;

	always_comb begin
		// ping watchdog
		if (tick.ping_seen) begin
			ping_inc = '0;
		end else if (ping_cnt_q != PING_CNT_MAX) begin
			ping_inc = ping_cnt_q + 1'b1;
		end else begin
			ping_inc = ping_cnt_q;
		end
		restart  = (ping_inc > cfg.ping_timeout);
		ping_nxt = restart ? '0 : ping_inc;

		// no-sensor watchdog, on the flag left by earlier ticks
		if (!no_sens_q) begin
			sens_nxt = '0;
		end else if (sens_cnt_q != SENS_CNT_MAX) begin
			sens_nxt = sens_cnt_q + 1'b1;
		end else begin
			sens_nxt = sens_cnt_q;
		end
		reboot = (sens_nxt > cfg.sensor_timeout);

		// link LED
		lcol_nxt   = lcol_q;
		lflash_nxt = lflash_q;
		if (tick.fw_updating) begin
			lcol_nxt = COL_YELLOW;
		end else begin
			case (tick.link_state) inside
				LS_CONNECTING: lcol_nxt = COL_RED;
				LS_WPS: begin
					lcol_nxt   = COL_BLUE;
					lflash_nxt = 1'b1;
				end
				LS_CONNECTED: lcol_nxt = COL_YELLOW;
				LS_READY, LS_IP: begin
					lcol_nxt   = COL_GREEN;
					lflash_nxt = 1'b0;
				end
				default: ;
			endcase
		end

		// fan fault latch; supply fan wins
		if (tick.fan_faults[1]) begin
			fan_err = ERR_SUPPLY;
		end else if (tick.fan_faults[0]) begin
			fan_err = ERR_EXHAUST;
		end else begin
			fan_err = ERR_NONE;
		end
		timer_nxt   = timer_q;
		latched_nxt = latched_q;
		ack_nxt     = ack_q;
		err         = fan_err;
		if (fan_err == ERR_NONE) begin
			timer_nxt = cfg.motor_fault_delay;
			ack_nxt   = 1'b0;
		end else if (timer_q == '0) begin
			latched_nxt = fan_err[1:0];
		end else begin
			timer_nxt = timer_q - 1'b1;
		end
		if (latched_nxt != '0) begin
			if (ack_nxt) begin
				err = ERR_NONE;
			end else begin
				err = CODE_W'(latched_nxt);
				if (tick.clear_pressed) begin
					latched_nxt = '0;
					timer_nxt   = cfg.motor_fault_delay;
					ack_nxt     = 1'b1;
				end
			end
		end

		if (tick.temp_faults[0]) begin
			err = ERR_INDOOR;
		end
		if (tick.temp_faults[1]) begin
			err = ERR_OUTDOOR;
		end

		// sensor checks only when connect ready
		no_sens_nxt = no_sens_q;
		if (tick.link_state == LS_READY) begin
			if (scan.ok_short) begin
				err         = ERR_SENSORS;
				no_sens_nxt = scan.none_ok;
			end
			if (scan.co2_bad) begin
				err = ERR_SENSORS;
			end
		end

		// fault LED
		fflash_nxt = fflash_q;
		if (err == ERR_NONE) begin
			if (tick.ventilation_off) begin
				fcol       = COL_YELLOW;
				fflash_nxt = 1'b1;
			end else begin
				fcol       = tick.exhaust_turning ? COL_GREEN : COL_OFF;
				fflash_nxt = 1'b0;
			end
		end else begin
			fcol = COL_RED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ping_cnt_q <= '0;
			sens_cnt_q <= '0;
			no_sens_q  <= 1'b0;
			timer_q    <= DELAY_RST;
			latched_q  <= '0;
			ack_q      <= 1'b0;
			lcol_q     <= COL_OFF;
			lflash_q   <= 1'b0;
			fflash_q   <= 1'b0;
		end else if (commit) begin
			ping_cnt_q <= ping_nxt;
			sens_cnt_q <= sens_nxt;
			no_sens_q  <= no_sens_nxt;
			timer_q    <= timer_nxt;
			latched_q  <= latched_nxt;
			ack_q      <= ack_nxt;
			lcol_q     <= lcol_nxt;
			lflash_q   <= lflash_nxt;
			fflash_q   <= fflash_nxt;
		end
	end

	assign res.error_code     = err;
	assign res.link_color     = lcol_nxt;
	assign res.link_flash     = lflash_nxt;
	assign res.fault_color    = fcol;
	assign res.fault_flash    = fflash_nxt;
	assign res.restart_link   = restart;
	assign res.reboot_request = reboot;

`ifndef NO_ASSERTIONS
	a_ping_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && restart) |=> (ping_cnt_q == '0))
		else $error("ping counter not cleared after link restart");
	a_ack_clears_latch: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && !ack_q && ack_nxt) |=> (latched_q == '0))
		else $error("fault acknowledged but still latched");
	a_fault_red: assert property (@(posedge clk) disable iff (!arst_n)
		(err != ERR_NONE) |-> (fcol == COL_RED))
		else $error("fault LED not red with an active error");
`endif

endmodule

// ----- tb/health_supervisor_fault_latch_tb.sv -----
// Self-checking bench for the health supervisor: queued words, shadow model, scoreboard.
module health_supervisor_fault_latch_tb;
	import hsfl_pkg::*;

	localparam int SLOTS       = SENSOR_SLOTS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 24;
	localparam int PHASE_WORDS = 125;
	localparam int PHASES      = 8;
	localparam int HOLD_CYCLES = 400;

	// link states without a package name, and a register index that decodes to nothing
	localparam logic [LINK_W-1:0] LS_OTHER   = 3'd0;
	localparam logic [LINK_W-1:0] LS_SPARE_A = 3'd6;
	localparam logic [LINK_W-1:0] LS_SPARE_B = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic              mode;
		logic [IDX_W-1:0]  sensor_index;
		logic              sensor_ok;
		logic [CO2_W-1:0]  co2_value;
		logic              ping_seen;
		logic              fw_updating;
		logic [LINK_W-1:0] link_state;
		logic [1:0]        fan_faults;
		logic              clear_pressed;
		logic [1:0]        temp_faults;
		logic              exhaust_turning;
		logic              ventilation_off;
	} sup_word_t;

	logic clk;
	logic arst_n;

	hsfl_item_if   item_ch ();
	hsfl_result_if res_ch ();
	hsfl_cfg_if    cfg_ch ();

	health_supervisor_fault_latch dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// shadow of the block
	hsfl_cfg_t          regs;
	logic               slot_ok [SLOTS];
	logic [CO2_W-1:0]   slot_co2 [SLOTS];
	logic [PING_W-1:0]  ping_idle;
	logic [SENS_W-1:0]  silent_ticks;
	logic               none_ok_flag;
	logic [DELAY_W-1:0] fan_timer;
	logic [CODE_W-1:0]  fan_latch;
	logic               fan_acked;
	logic [COLOR_W-1:0] led_link;
	logic               led_link_flash;
	logic               led_fault_flash;

	sup_word_t    pending_words[$];
	hsfl_result_t expected_results[$];
	sup_word_t    cur_word;
	logic         word_taken;
	int           gap_left;
	int           stall_left;
	int           hold_left;
	logic         hold_req;
	logic         quiet;
	logic [1:0]   fan_hold;
	int           errors;
	int           cycles;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_REQUIRED: regs.required_sensors = val[REQ_W-1:0];
			REG_DELAY:    regs.motor_fault_delay = val[DELAY_W-1:0];
			REG_PING:     regs.ping_timeout = val[PING_W-1:0];
			REG_SENSOR:   regs.sensor_timeout = val[SENS_W-1:0];
			REG_CO2_LOW:  regs.co2_low = val[CO2_W-1:0];
			REG_CO2_HIGH: regs.co2_high = val[CO2_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic hsfl_result_t supervise_tick(sup_word_t w);
		hsfl_result_t r;
		logic [CODE_W-1:0] err;
		int okc;
		r = '0;
		err = ERR_NONE;

		if (w.ping_seen)
			ping_idle = '0;
		else if (ping_idle != PING_CNT_MAX)
			ping_idle++;
		if (ping_idle > regs.ping_timeout) begin
			ping_idle = '0;
			r.restart_link = 1'b1;
		end

		// flag is the one left by earlier ticks
		if (none_ok_flag) begin
			if (silent_ticks != SENS_CNT_MAX)
				silent_ticks++;
		end else begin
			silent_ticks = '0;
		end
		r.reboot_request = silent_ticks > regs.sensor_timeout;

		if (w.fw_updating) begin
			led_link = COL_YELLOW;
		end else begin
			case (w.link_state)
				LS_CONNECTING: led_link = COL_RED;
				LS_WPS: begin
					led_link_flash = 1'b1;
					led_link = COL_BLUE;
				end
				LS_CONNECTED: led_link = COL_YELLOW;
				LS_READY, LS_IP: begin
					led_link_flash = 1'b0;
					led_link = COL_GREEN;
				end
				default: ;
			endcase
		end

		if (w.fan_faults[0]) err = ERR_EXHAUST;
		if (w.fan_faults[1]) err = ERR_SUPPLY;
		if (err == ERR_NONE) begin
			fan_timer = regs.motor_fault_delay;
			fan_acked = 1'b0;
		end else if (fan_timer == '0) begin
			fan_latch = err;
		end else begin
			fan_timer--;
		end
		if (fan_latch != ERR_NONE) begin
			if (fan_acked) begin
				err = ERR_NONE;
			end else begin
				err = fan_latch;
				if (w.clear_pressed) begin
					fan_latch = ERR_NONE;
					fan_timer = regs.motor_fault_delay;
					fan_acked = 1'b1;
				end
			end
		end

		if (w.temp_faults[0]) err = ERR_INDOOR;
		if (w.temp_faults[1]) err = ERR_OUTDOOR;

		if (w.link_state == LS_READY) begin
			okc = 0;
			for (int n = 0; n < SLOTS; n++)
				if (slot_ok[n]) okc++;
			if (okc < regs.required_sensors) begin
				err = ERR_SENSORS;
				none_ok_flag = (okc == 0);
			end
			for (int n = 1; n < regs.required_sensors && n < SLOTS; n++)
				if (slot_co2[n] < regs.co2_low || slot_co2[n] > regs.co2_high)
					err = ERR_SENSORS;
		end

		if (err == ERR_NONE) begin
			if (w.ventilation_off) begin
				r.fault_color = COL_YELLOW;
				led_fault_flash = 1'b1;
			end else begin
				led_fault_flash = 1'b0;
				r.fault_color = w.exhaust_turning ? COL_GREEN : COL_OFF;
			end
		end else begin
			r.fault_color = COL_RED;
		end

		r.error_code = err;
		r.link_color = led_link;
		r.link_flash = led_link_flash;
		r.fault_flash = led_fault_flash;
		return r;
	endfunction

	function automatic void take_word(sup_word_t w);
		if (w.mode == MODE_TICK) begin
			expected_results.push_back(supervise_tick(w));
		end else if (w.sensor_index < SLOTS) begin
			slot_ok[w.sensor_index] = w.sensor_ok;
			slot_co2[w.sensor_index] = w.co2_value;
		end
	endfunction

	function automatic sup_word_t tick_base();
		sup_word_t w;
		w = '0;
		w.mode = MODE_TICK;
		return w;
	endfunction

	function automatic sup_word_t report_word(int idx, logic ok, logic [CO2_W-1:0] co2);
		sup_word_t w;
		w = '0;
		w.mode = MODE_REPORT;
		w.sensor_index = IDX_W'(idx);
		w.sensor_ok = ok;
		w.co2_value = co2;
		return w;
	endfunction

	function automatic sup_word_t random_word();
		sup_word_t w;
		int pick;
		w = sup_word_t'({$urandom, $urandom});
		if ($urandom_range(0, 9) < 3) begin
			w.mode = MODE_REPORT;
			w.sensor_ok = $urandom_range(0, 9) < 7;
			pick = $urandom_range(0, 3);
			if (pick == 0)
				w.co2_value = $urandom_range(0, 1) ? '1 : '0;
			else if (pick == 1 && regs.co2_low <= regs.co2_high)
				w.co2_value = CO2_W'($urandom_range(regs.co2_low, regs.co2_high));
			else if (pick == 2)
				w.co2_value = CO2_W'($urandom_range(250, 20050));
		end else begin
			w.mode = MODE_TICK;
			w.ping_seen = $urandom_range(0, 3) == 0;
			w.fw_updating = $urandom_range(0, 7) == 0;
			if ($urandom_range(0, 9) < 4)
				w.link_state = LS_READY;
			// fans change rarely so that faults persist long enough to latch
			if ($urandom_range(0, 4) == 0)
				fan_hold = 2'($urandom_range(0, 3));
			w.fan_faults = fan_hold;
			w.clear_pressed = $urandom_range(0, 5) == 0;
			if ($urandom_range(0, 4) != 0)
				w.temp_faults = '0;
		end
		return w;
	endfunction

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val, int width);
		logic [CFG_DATA_W-1:0] mask;
		logic [CFG_DATA_W-1:0] data;
		mask = CFG_DATA_W'((64'd1 << width) - 1);
		// bits above the register width are junk and must be dropped
		data = (CFG_DATA_W'($urandom) & ~mask) | (CFG_DATA_W'(val) & mask);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		apply_reg(idx, data);
	endtask

	task automatic load_config(int unsigned req, int unsigned delay, int unsigned ping,
			int unsigned sens, int unsigned lo, int unsigned hi);
		write_reg(REG_REQUIRED, req, REQ_W);
		write_reg(REG_DELAY, delay, DELAY_W);
		write_reg(REG_PING, ping, PING_W);
		write_reg(REG_SENSOR, sens, SENS_W);
		write_reg(REG_CO2_LOW, lo, CO2_W);
		write_reg(REG_CO2_HIGH, hi, CO2_W);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (pending_words.size() != 0 || item_ch.valid || expected_results.size() != 0)
			@(posedge clk);
		// a trailing report leaves no result behind, so give the block time to settle
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// monitor: acceptance of words and checking of results
	always @(posedge clk) begin
		hsfl_result_t want;
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready) begin
				word_taken = 1'b1;
				take_word(cur_word);
			end
			if (res_ch.valid && res_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("result word with nothing expected");
					errors++;
				end else begin
					want = expected_results.pop_front();
					check_field("error_code", want.error_code, res_ch.error_code);
					check_field("link_color", want.link_color, res_ch.link_color);
					check_field("link_flash", want.link_flash, res_ch.link_flash);
					check_field("fault_color", want.fault_color, res_ch.fault_color);
					check_field("fault_flash", want.fault_flash, res_ch.fault_flash);
					check_field("restart_link", want.restart_link, res_ch.restart_link);
					check_field("reboot_request", want.reboot_request, res_ch.reboot_request);
				end
			end
		end
	end

	// driver of the item channel
	always @(negedge clk) begin
		if (arst_n && (!item_ch.valid || word_taken)) begin
			word_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				item_ch.valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				gap_left = $urandom_range(1, 7) - 1;
				item_ch.valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				cur_word = pending_words.pop_front();
				item_ch.valid <= 1'b1;
				item_ch.mode <= cur_word.mode;
				item_ch.sensor_index <= cur_word.sensor_index;
				item_ch.sensor_ok <= cur_word.sensor_ok;
				item_ch.co2_value <= cur_word.co2_value;
				item_ch.ping_seen <= cur_word.ping_seen;
				item_ch.fw_updating <= cur_word.fw_updating;
				item_ch.link_state <= cur_word.link_state;
				item_ch.fan_faults <= cur_word.fan_faults;
				item_ch.clear_pressed <= cur_word.clear_pressed;
				item_ch.temp_faults <= cur_word.temp_faults;
				item_ch.exhaust_turning <= cur_word.exhaust_turning;
				item_ch.ventilation_off <= cur_word.ventilation_off;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver: short stalls plus one long hold-off on request
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				res_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 7) - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		sup_word_t w;
		int unsigned lo;
		logic [LINK_W-1:0] link_walk [8];
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.mode = MODE_REPORT;
		item_ch.sensor_index = '0;
		item_ch.sensor_ok = 1'b0;
		item_ch.co2_value = '0;
		item_ch.ping_seen = 1'b0;
		item_ch.fw_updating = 1'b0;
		item_ch.link_state = LS_OTHER;
		item_ch.fan_faults = '0;
		item_ch.clear_pressed = 1'b0;
		item_ch.temp_faults = '0;
		item_ch.exhaust_turning = 1'b0;
		item_ch.ventilation_off = 1'b0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_REQUIRED;
		cfg_ch.data = '0;
		cur_word = '0;
		word_taken = 1'b0;
		gap_left = 0;
		stall_left = 0;
		hold_left = 0;
		hold_req = 1'b0;
		quiet = 1'b0;
		fan_hold = '0;
		errors = 0;
		cycles = 0;

		regs.required_sensors = REQUIRED_RST;
		regs.motor_fault_delay = DELAY_RST;
		regs.ping_timeout = PING_RST;
		regs.sensor_timeout = SENSOR_RST;
		regs.co2_low = CO2_LOW_RST;
		regs.co2_high = CO2_HIGH_RST;
		for (int n = 0; n < SLOTS; n++) begin
			slot_ok[n] = 1'b0;
			slot_co2[n] = '0;
		end
		ping_idle = '0;
		silent_ticks = '0;
		none_ok_flag = 1'b0;
		fan_timer = DELAY_RST;
		fan_latch = ERR_NONE;
		fan_acked = 1'b0;
		led_link = COL_OFF;
		led_link_flash = 1'b0;
		led_fault_flash = 1'b0;

		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// directed words under the reset settings
		pending_words.push_back(tick_base());
		pending_words.push_back(report_word(0, 1'b1, '0));
		pending_words.push_back(report_word(SLOTS - 1, 1'b0, '1));
		link_walk = '{LS_READY, LS_CONNECTING, LS_WPS, LS_CONNECTED, LS_IP, LS_SPARE_A,
			LS_SPARE_B, LS_OTHER};
		foreach (link_walk[k]) begin
			w = tick_base();
			w.link_state = link_walk[k];
			pending_words.push_back(w);
		end
		w = tick_base();
		w.fw_updating = 1'b1;
		w.link_state = LS_WPS;
		pending_words.push_back(w);
		pending_words.push_back(report_word(0, 1'b0, 16'd400));
		w = tick_base();
		w.link_state = LS_READY;
		pending_words.push_back(w);
		for (int f = 1; f <= 3; f++) begin
			w = tick_base();
			w.fan_faults = 2'(f);
			w.clear_pressed = (f == 3);
			pending_words.push_back(w);
			w = tick_base();
			w.temp_faults = 2'(f);
			pending_words.push_back(w);
		end
		w = tick_base();
		w.ventilation_off = 1'b1;
		pending_words.push_back(w);
		w = tick_base();
		w.exhaust_turning = 1'b1;
		w.ping_seen = 1'b1;
		pending_words.push_back(w);
		pending_words.push_back(report_word(3, 1'b1, 16'd1000));
		w = '1;
		w.link_state = LS_READY;
		pending_words.push_back(w);
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: load_config(0, 0, 0, 0, 0, 16'hFFFF);
				1: load_config(SLOTS, 1, 1, 1, CO2_LOW_RST, CO2_HIGH_RST);
				2: load_config(15, 8'hFF, PING_CNT_MAX, SENS_CNT_MAX, 16'hFFFF, 0);
				3: begin
					load_config(4, 2, 5, 3, 100, 30000);
					write_reg(REG_UNUSED, $urandom, CFG_DATA_W);
					@(negedge clk);
					cfg_ch.valid <= 1'b0;
				end
				default: begin
					lo = $urandom_range(0, 20000);
					load_config($urandom_range(0, 9) < 8 ? $urandom_range(0, SLOTS)
						: $urandom_range(0, 15), $urandom_range(0, 6),
						$urandom_range(0, 12), $urandom_range(0, 10), lo,
						lo + $urandom_range(0, 40000));
				end
			endcase
			quiet = (p == PHASES - 1);
			for (int i = 0; i < PHASE_WORDS; i++)
				pending_words.push_back(random_word());
			if (p == 4)
				hold_req = 1'b1;
			wait_drained();
		end

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
